### rtl/core/dlc_pkg.sv
`timescale 1ns / 1ps
// dlc_pkg: shared types, codes and constants of the door lock controller
// no dependencies; imported by every module of the block

package dlc_pkg;

	// register reset values
	localparam logic [31:0] UNLOCK_TIMEOUT_RST = 32'd10000;
	localparam logic [31:0] OPEN_DEBOUNCE_RST  = 32'd500;
	localparam logic [31:0] OPEN_ALERT_RST     = 32'd60000;

	// configuration register indexes
	localparam logic [1:0] REG_UNLOCK_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_OPEN_DEBOUNCE  = 2'd1;
	localparam logic [1:0] REG_OPEN_ALERT     = 2'd2;

	// request kinds
	typedef enum logic [2:0] {
		MODE_POLL   = 3'd0,
		MODE_UNLOCK = 3'd1,
		MODE_LOCK   = 3'd2,
		MODE_READ   = 3'd3,
		MODE_START  = 3'd4
	} mode_t;

	// door state machine, one-hot
	typedef enum logic [2:0] {
		ST_LOCKED   = 3'b001,
		ST_WAIT     = 3'b010,
		ST_UNLOCKED = 3'b100
	} door_state_t;

	// reported lock state codes
	localparam logic [1:0] LOCK_CODE_LOCKED   = 2'd0;
	localparam logic [1:0] LOCK_CODE_WAIT     = 2'd1;
	localparam logic [1:0] LOCK_CODE_UNLOCKED = 2'd2;

	// servo commands
	localparam logic [1:0] SERVO_NONE   = 2'd0;
	localparam logic [1:0] SERVO_LOCK   = 2'd1;
	localparam logic [1:0] SERVO_UNLOCK = 2'd2;

	// message codes
	localparam logic [1:0] MSG_NONE        = 2'd0;
	localparam logic [1:0] MSG_AUTO_LOCKED = 2'd1;
	localparam logic [1:0] MSG_OPEN_LONG   = 2'd2;
	localparam logic [1:0] MSG_LOCK_FAILED = 2'd3;

	// event latch bit positions
	localparam int EV_LOCK   = 0;
	localparam int EV_UNLOCK = 1;
	localparam int EV_FAIL   = 2;
	localparam int EV_LONG   = 3;

	typedef struct packed {
		logic [31:0] unlock_timeout_ms;
		logic [31:0] open_debounce_ms;
		logic [31:0] open_alert_ms;
	} cfg_t;

	typedef struct packed {
		mode_t       mode;
		logic [31:0] now_ms;
		logic        mag_near;
		logic        close_event;
	} item_t;

	typedef struct packed {
		logic [1:0] lock_state;
		logic [1:0] servo_action;
		logic [1:0] message_code;
		logic [3:0] events;
	} result_t;

	// map the one-hot state onto its reported code
	function automatic logic [1:0] lock_code(door_state_t st);
		logic [1:0] code;
		unique case (st)
			ST_LOCKED:   code = LOCK_CODE_LOCKED;
			ST_WAIT:     code = LOCK_CODE_WAIT;
			ST_UNLOCKED: code = LOCK_CODE_UNLOCKED;
			default:     code = LOCK_CODE_LOCKED;
		endcase
		return code;
	endfunction

endpackage

### rtl/core/dlc_cfg_regs.sv
`timescale 1ns / 1ps
// dlc_cfg_regs: the three timing registers and their write port
// depends on dlc_pkg

module dlc_cfg_regs
	import dlc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	// register write decode, writes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unlock_timeout_ms <= UNLOCK_TIMEOUT_RST;
			cfg_q.open_debounce_ms  <= OPEN_DEBOUNCE_RST;
			cfg_q.open_alert_ms     <= OPEN_ALERT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_UNLOCK_TIMEOUT: cfg_q.unlock_timeout_ms <= cfg_data;
				REG_OPEN_DEBOUNCE:  cfg_q.open_debounce_ms  <= cfg_data;
				REG_OPEN_ALERT:     cfg_q.open_alert_ms     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/dlc_lock_fsm.sv
`timescale 1ns / 1ps
// dlc_lock_fsm: door state, timers and event latches with the per-request update
// depends on dlc_pkg; driven by the input stage of the top level

module dlc_lock_fsm
	import dlc_pkg::*;
#(
	parameter int TIME_WIDTH = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t result
);

	localparam int TW = TIME_WIDTH;
	localparam int CW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

	// state registers
	door_state_t   door_q;
	logic          dbc_active_q;
	logic [TW-1:0] dbc_start_q;
	logic [TW-1:0] deadline_q;
	logic          open_track_q;
	logic [TW-1:0] open_since_q;
	logic          alert_sent_q;
	logic [3:0]    events_q;

	// next values
	door_state_t   door_n;
	logic          dbc_active_n;
	logic [TW-1:0] dbc_start_n;
	logic [TW-1:0] deadline_n;
	logic          open_track_n;
	logic [TW-1:0] open_since_n;
	logic          alert_sent_n;
	logic [3:0]    events_n;
	logic [1:0]    servo;
	logic [1:0]    msg;
	logic [3:0]    ev_out;

	logic [CW-1:0] now_ext;
	logic [TW-1:0] now_t;
	logic [TW-1:0] new_deadline;
	logic [TW-1:0] dl_diff;
	logic          dl_passed;
	logic          dbc_done;
	logic          alert_due;
	logic          mag;

	// wrapped time since start compared against a full register value
	function automatic logic elapsed(logic [TW-1:0] now, logic [TW-1:0] start,
		logic [31:0] dt);
		logic [TW-1:0] diff;
		diff = now - start;
		return CW'(diff) >= CW'(dt);
	endfunction

	assign now_ext      = CW'(item.now_ms);
	assign now_t        = now_ext[TW-1:0];
	assign mag          = item.mag_near;
	assign new_deadline = now_t + TW'(CW'(cfg.unlock_timeout_ms));
	assign dl_diff      = deadline_q - now_t;
	assign dl_passed    = (dl_diff == '0) || dl_diff[TW-1];
	assign dbc_done     = elapsed(now_t, dbc_start_q, cfg.open_debounce_ms);
	assign alert_due    = elapsed(now_t, open_since_q, cfg.open_alert_ms);

	// request update, written in the order the steps take effect
	always_comb begin
		door_n       = door_q;
		dbc_active_n = dbc_active_q;
		dbc_start_n  = dbc_start_q;
		deadline_n   = deadline_q;
		open_track_n = open_track_q;
		open_since_n = open_since_q;
		alert_sent_n = alert_sent_q;
		events_n     = events_q;
		servo        = SERVO_NONE;
		msg          = MSG_NONE;
		ev_out       = '0;
		case (item.mode)
			MODE_POLL: begin
				if (item.close_event && door_q != ST_LOCKED) begin
					// confirmed close locks at once
					servo           = SERVO_LOCK;
					door_n          = ST_LOCKED;
					dbc_active_n    = 1'b0;
					open_track_n    = 1'b0;
					events_n[EV_LOCK] = 1'b1;
				end else begin
					if (door_q == ST_WAIT) begin
						// open debounce
						if (!dbc_active_q) begin
							if (!mag) begin
								dbc_active_n = 1'b1;
								dbc_start_n  = now_t;
							end
						end else if (mag) begin
							dbc_active_n = 1'b0;
						end else if (dbc_done) begin
							door_n       = ST_UNLOCKED;
							dbc_active_n = 1'b0;
						end
						// forgot-to-open deadline
						if (dl_passed) begin
							if (mag) begin
								servo             = SERVO_LOCK;
								door_n            = ST_LOCKED;
								dbc_active_n      = 1'b0;
								open_track_n      = 1'b0;
								events_n[EV_LOCK] = 1'b1;
								msg               = MSG_AUTO_LOCKED;
							end else begin
								door_n       = ST_UNLOCKED;
								dbc_active_n = 1'b0;
							end
						end
					end
					// open-too-long alert
					if (door_n == ST_UNLOCKED) begin
						if (!mag) begin
							if (!open_track_n) begin
								open_track_n = 1'b1;
								open_since_n = now_t;
							end else if (alert_due && !alert_sent_q) begin
								alert_sent_n = 1'b1;
								if (!events_n[EV_LONG]) begin
									events_n[EV_LONG] = 1'b1;
									msg               = MSG_OPEN_LONG;
								end
							end
						end else begin
							open_track_n = 1'b0;
							alert_sent_n = 1'b0;
						end
					end
				end
			end
			MODE_UNLOCK: begin
				if (door_q == ST_WAIT) begin
					servo        = SERVO_UNLOCK;
					deadline_n   = new_deadline;
					dbc_active_n = 1'b0;
				end else if (door_q != ST_UNLOCKED) begin
					servo               = SERVO_UNLOCK;
					door_n              = ST_WAIT;
					deadline_n          = new_deadline;
					dbc_active_n        = 1'b0;
					open_track_n        = 1'b0;
					events_n[EV_UNLOCK] = 1'b1;
				end
			end
			MODE_LOCK: begin
				if (door_q != ST_LOCKED) begin
					if (mag) begin
						servo             = SERVO_LOCK;
						door_n            = ST_LOCKED;
						dbc_active_n      = 1'b0;
						open_track_n      = 1'b0;
						events_n[EV_LOCK] = 1'b1;
					end else begin
						events_n[EV_FAIL] = 1'b1;
						msg               = MSG_LOCK_FAILED;
					end
				end
			end
			MODE_READ: begin
				ev_out   = events_q;
				events_n = '0;
			end
			MODE_START: begin
				if (mag) begin
					servo             = SERVO_LOCK;
					door_n            = ST_LOCKED;
					dbc_active_n      = 1'b0;
					open_track_n      = 1'b0;
					events_n[EV_LOCK] = 1'b1;
				end else begin
					servo  = SERVO_UNLOCK;
					door_n = ST_UNLOCKED;
				end
			end
			default: ;
		endcase
	end

	// state commit on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			door_q       <= ST_LOCKED;
			dbc_active_q <= 1'b0;
			dbc_start_q  <= '0;
			deadline_q   <= '0;
			open_track_q <= 1'b0;
			open_since_q <= '0;
			alert_sent_q <= 1'b0;
			events_q     <= '0;
		end else if (fire) begin
			door_q       <= door_n;
			dbc_active_q <= dbc_active_n;
			dbc_start_q  <= dbc_start_n;
			deadline_q   <= deadline_n;
			open_track_q <= open_track_n;
			open_since_q <= open_since_n;
			alert_sent_q <= alert_sent_n;
			events_q     <= events_n;
		end
	end

	assign result.lock_state   = lock_code(door_n);
	assign result.servo_action = servo;
	assign result.message_code = msg;
	assign result.events       = ev_out;

endmodule

### rtl/core/door_lock_controller_top.sv
`timescale 1ns / 1ps
// door_lock_controller_top: request register, lock state machine, result register
// depends on dlc_pkg, dlc_cfg_regs and dlc_lock_fsm
//
// channel | direction | handshake              | payload
// s_*     | in        | s_tvalid / s_tready    | s_tuser mode, s_tdata time and sensors
// m_*     | out       | m_tvalid / m_tready    | m_tdata state, servo, message, events
// cfg_*   | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one request per cycle sustained while m_tready keeps the result register draining;
// an accepted request moves on from the request register into the result register
// the state machine updates as a request moves from the request register
// into the result register; a stalled result holds the request register,
// and s_tready stays high while either register is free or draining
// reset is asynchronous and leaves the lock locked with timing registers at default

module door_lock_controller_top
	import dlc_pkg::*;
#(
	parameter int TIME_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // now_ms[31:0], mag_near[32], close_event[33], zero
	input  logic [2:0]  s_tuser,  // mode[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // lock_state[1:0], servo_action[3:2], message_code[5:4],
	                              // lock_event[6], unlock_event[7], failed_lock_event[8],
	                              // open_long_event[9], zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t result;
	result_t result_s2;
	logic    valid_s2;
	logic    advance;

	// configuration registers
	assign cfg_ready = 1'b1;

	dlc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// pipeline control
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.mode        <= mode_t'(s_tuser);
			item_s1.now_ms      <= s_tdata[31:0];
			item_s1.mag_near    <= s_tdata[32];
			item_s1.close_event <= s_tdata[33];
		end
	end

	// lock state machine
	dlc_lock_fsm #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, result_s2.events, result_s2.message_code,
		result_s2.servo_action, result_s2.lock_state};

	// a free result register never holds back requests
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_tready)
		else $error("request stalled with empty result register");

	// a lock drive always leaves the door locked
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[3:2] == SERVO_LOCK) |-> (m_tdata[1:0] == LOCK_CODE_LOCKED))
		else $error("lock drive without locked state");

	// an unlock drive never leaves the door locked
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[3:2] == SERVO_UNLOCK) |-> (m_tdata[1:0] != LOCK_CODE_LOCKED))
		else $error("unlock drive with locked state");

	// auto-lock message only with a lock drive
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[5:4] == MSG_AUTO_LOCKED) |-> (m_tdata[3:2] == SERVO_LOCK))
		else $error("auto-lock message without lock drive");

endmodule

### tb/sv/door_lock_monitor.sv
`timescale 1ns / 1ps
// door_lock_monitor: watches the request, status and timing channels of the lock controller,
// predicts each status word and compares it field by field; depends on dlc_pkg

module door_lock_monitor
	import dlc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,  // now_ms[31:0], mag_near[32], close_event[33], zero
	input  logic [2:0]  s_tuser,  // mode[2:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,  // lock_state[1:0], servo_action[3:2], message_code[5:4],
	                              // lock_event[6], unlock_event[7], failed_lock_event[8],
	                              // open_long_event[9], zero
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          pending
);

	localparam int REPORT_LIMIT = 10;

	// timing registers as the lock sees them
	logic [31:0] unlock_window;
	logic [31:0] debounce_window;
	logic [31:0] alert_window;

	// lock state mirror
	logic [1:0]  lock_now;
	logic        debouncing;
	logic [31:0] debounce_t0;
	logic [31:0] open_deadline;
	logic        tracking_open;
	logic [31:0] open_t0;
	logic        alert_done;
	logic [3:0]  latched;

	result_t status_due[$];
	int      mismatches = 0;

	assign errors = mismatches;

	// drive the bolt home and forget any open-door timing
	task automatic seize_lock(inout logic [1:0] servo);
		servo         = SERVO_LOCK;
		lock_now      = LOCK_CODE_LOCKED;
		debouncing    = 1'b0;
		tracking_open = 1'b0;
		latched[EV_LOCK] = 1'b1;
	endtask

	// advance the mirror by one request and give the status it should produce
	task automatic apply_request(input logic [2:0] mode, input logic [31:0] now,
			input logic mag, input logic closed, output result_t res);
		logic [1:0]  servo;
		logic [1:0]  msg;
		logic [3:0]  ev;
		logic [31:0] left;
		servo = SERVO_NONE;
		msg   = MSG_NONE;
		ev    = 4'd0;
		case (mode)
			MODE_POLL: begin
				if (closed && lock_now != LOCK_CODE_LOCKED) begin
					seize_lock(servo);
				end else begin
					// waiting for the door to open: debounce, then the deadline
					if (lock_now == LOCK_CODE_WAIT) begin
						if (!debouncing) begin
							if (!mag) begin
								debouncing  = 1'b1;
								debounce_t0 = now;
							end
						end else begin
							if (!mag && (now - debounce_t0) >= debounce_window) begin
								lock_now   = LOCK_CODE_UNLOCKED;
								debouncing = 1'b0;
							end
							if (mag)
								debouncing = 1'b0;
						end
						left = open_deadline - now;
						if (left == 32'd0 || left[31]) begin
							if (mag) begin
								seize_lock(servo);
								msg = MSG_AUTO_LOCKED;
							end else begin
								lock_now   = LOCK_CODE_UNLOCKED;
								debouncing = 1'b0;
							end
						end
					end
					// door open too long, reported once per opening
					if (lock_now == LOCK_CODE_UNLOCKED) begin
						if (!mag) begin
							if (!tracking_open) begin
								tracking_open = 1'b1;
								open_t0       = now;
							end else if ((now - open_t0) >= alert_window && !alert_done) begin
								alert_done = 1'b1;
								if (!latched[EV_LONG]) begin
									latched[EV_LONG] = 1'b1;
									msg = MSG_OPEN_LONG;
								end
							end
						end else begin
							tracking_open = 1'b0;
							alert_done    = 1'b0;
						end
					end
				end
			end
			MODE_UNLOCK: begin
				if (lock_now == LOCK_CODE_WAIT) begin
					servo         = SERVO_UNLOCK;
					open_deadline = now + unlock_window;
					debouncing    = 1'b0;
				end else if (lock_now == LOCK_CODE_LOCKED) begin
					servo         = SERVO_UNLOCK;
					lock_now      = LOCK_CODE_WAIT;
					open_deadline = now + unlock_window;
					debouncing    = 1'b0;
					tracking_open = 1'b0;
					latched[EV_UNLOCK] = 1'b1;
				end
			end
			MODE_LOCK: begin
				if (lock_now != LOCK_CODE_LOCKED) begin
					if (mag) begin
						seize_lock(servo);
					end else begin
						latched[EV_FAIL] = 1'b1;
						msg = MSG_LOCK_FAILED;
					end
				end
			end
			MODE_READ: begin
				ev      = latched;
				latched = 4'd0;
			end
			MODE_START: begin
				if (mag) begin
					seize_lock(servo);
				end else begin
					servo    = SERVO_UNLOCK;
					lock_now = LOCK_CODE_UNLOCKED;
				end
			end
			default: ;
		endcase
		res.lock_state   = lock_now;
		res.servo_action = servo;
		res.message_code = msg;
		res.events       = ev;
	endtask

	// count and report one differing field
	function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
		if (want !== got) begin
			if (mismatches < REPORT_LIMIT)
				$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// follow every handshake at the clock edge
	always @(posedge clk or negedge arst_n) begin : watch
		result_t due;
		if (!arst_n) begin
			unlock_window   = UNLOCK_TIMEOUT_RST;
			debounce_window = OPEN_DEBOUNCE_RST;
			alert_window    = OPEN_ALERT_RST;
			lock_now        = LOCK_CODE_LOCKED;
			debouncing      = 1'b0;
			debounce_t0     = 32'd0;
			open_deadline   = 32'd0;
			tracking_open   = 1'b0;
			open_t0         = 32'd0;
			alert_done      = 1'b0;
			latched         = 4'd0;
			status_due.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_UNLOCK_TIMEOUT: unlock_window   = cfg_data;
					REG_OPEN_DEBOUNCE:  debounce_window = cfg_data;
					REG_OPEN_ALERT:     alert_window    = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				apply_request(s_tuser, s_tdata[31:0], s_tdata[32], s_tdata[33], due);
				status_due.push_back(due);
			end
			if (m_tvalid && m_tready) begin
				if (status_due.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t: status %0h with no request outstanding", $time, m_tdata);
					mismatches++;
				end else begin
					due = status_due.pop_front();
					check_field("lock_state", 4'(due.lock_state), 4'(m_tdata[1:0]));
					check_field("servo_action", 4'(due.servo_action), 4'(m_tdata[3:2]));
					check_field("message_code", 4'(due.message_code), 4'(m_tdata[5:4]));
					check_field("lock_event", 4'(due.events[EV_LOCK]), 4'(m_tdata[6]));
					check_field("unlock_event", 4'(due.events[EV_UNLOCK]), 4'(m_tdata[7]));
					check_field("failed_lock_event", 4'(due.events[EV_FAIL]), 4'(m_tdata[8]));
					check_field("open_long_event", 4'(due.events[EV_LONG]), 4'(m_tdata[9]));
				end
			end
			pending <= status_due.size();
		end
	end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: clock, reset and request traffic for door_lock_controller_top, with random stalls
// depends on dlc_pkg, door_lock_controller_top and door_lock_monitor

module tb;
	import dlc_pkg::*;

	// request kinds the lock does not define
	localparam logic [2:0] MODE_SPARE_LO = 3'd5;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;

	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 200;
	localparam int CALM_ITEMS   = 150;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 10;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	int          errors;
	int          pending;

	// traffic shaping
	int          send_gap_pct = 0;
	int          stall_pct = 0;
	bit          calm = 1'b0;
	int          step_max;
	int          flip_pct;
	logic [31:0] clock_ms;
	logic        door_closed;
	int          quiet = 0;

	door_lock_controller_top dut (.*);
	door_lock_monitor monitor (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// status side: random stall bursts
	initial begin
		int n;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && stall_pct > 0 && $urandom_range(99) < stall_pct) begin
				n = $urandom_range(1, 11);
				m_tready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// end the run when no channel has moved for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("door_lock_controller_top regression: fail");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// one request, after an optional gap
	task automatic send_request(input logic [2:0] mode, input logic [31:0] now,
			input logic mag, input logic close);
		int gap;
		gap = 0;
		if (!calm && send_gap_pct > 0 && $urandom_range(99) < send_gap_pct)
			gap = $urandom_range(1, 11);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {6'd0, close, mag, now};
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending until every status word is back
	task automatic drain_results;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// new timing set, written while the lock is idle
	task automatic retime(input logic [31:0] tmo, input logic [31:0] deb,
			input logic [31:0] alert);
		logic [1:0]  idx[3];
		logic [31:0] val[3];
		idx = '{REG_UNLOCK_TIMEOUT, REG_OPEN_DEBOUNCE, REG_OPEN_ALERT};
		val = '{tmo, deb, alert};
		drain_results();
		for (int i = 0; i < 3; i++) begin
			@(negedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_timing();
		case ($urandom_range(4))
			0:       return 32'd0;
			1:       return 32'd1;
			2:       return $urandom_range(1, 100);
			3:       return $urandom;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	// a request from the running scenario: time moves forward, the door opens and closes
	task automatic random_request;
		int          r;
		logic [2:0]  mode;
		logic [31:0] now;
		logic        mag;
		logic        close;
		clock_ms += $urandom_range(0, step_max);
		if ($urandom_range(99) < flip_pct)
			door_closed = !door_closed;
		now   = clock_ms;
		mag   = door_closed;
		close = ($urandom_range(99) < 6);
		r     = $urandom_range(99);
		if (r < 55)
			mode = MODE_POLL;
		else if (r < 67)
			mode = MODE_UNLOCK;
		else if (r < 77)
			mode = MODE_LOCK;
		else if (r < 87)
			mode = MODE_READ;
		else if (r < 92)
			mode = MODE_START;
		else begin
			// noise: any kind, any time, any sensor level
			mode  = 3'($urandom_range(7));
			now   = $urandom;
			mag   = 1'($urandom_range(1));
			close = 1'($urandom_range(1));
		end
		send_request(mode, now, mag, close);
	endtask

	initial begin
		s_tvalid    = 1'b0;
		s_tuser     = MODE_POLL;
		s_tdata     = '0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_UNLOCK_TIMEOUT;
		cfg_data    = '0;
		door_closed = 1'b1;
		clock_ms    = 32'd0;
		arst_n      = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed walk through the lock under reset timing
		send_gap_pct = 15;
		stall_pct    = 15;
		send_request(MODE_READ, 32'd0, 1'b1, 1'b0);
		send_request(MODE_START, 32'd0, 1'b0, 1'b0);          // start with door open
		send_request(MODE_POLL, 32'd1000, 1'b0, 1'b0);
		send_request(MODE_POLL, 32'd61000, 1'b0, 1'b0);       // open too long
		send_request(MODE_POLL, 32'd70000, 1'b0, 1'b0);       // alert already given
		send_request(MODE_READ, 32'd70001, 1'b0, 1'b0);
		send_request(MODE_LOCK, 32'd70002, 1'b0, 1'b0);       // lock fails, door open
		send_request(MODE_LOCK, 32'd70003, 1'b1, 1'b0);
		send_request(MODE_POLL, 32'd70004, 1'b1, 1'b1);       // close event while locked
		send_request(MODE_UNLOCK, 32'd100, 1'b1, 1'b1);       // close event outside poll
		send_request(MODE_UNLOCK, 32'd200, 1'b1, 1'b0);       // deadline refresh
		send_request(MODE_POLL, 32'd10200, 1'b1, 1'b0);       // deadline hit exactly, auto-lock
		send_request(MODE_UNLOCK, 32'hFFFF_FF00, 1'b1, 1'b0); // deadline wraps
		send_request(MODE_POLL, 32'hFFFF_FF10, 1'b0, 1'b0);
		send_request(MODE_POLL, 32'h0000_0104, 1'b0, 1'b0);   // debounce across the wrap
		send_request(MODE_POLL, 32'h0000_0105, 1'b0, 1'b1);   // confirmed close
		send_request(MODE_READ, 32'h0000_0106, 1'b1, 1'b0);
		send_request(MODE_UNLOCK, 32'd5000, 1'b1, 1'b0);
		send_request(MODE_POLL, 32'd20000, 1'b0, 1'b0);       // deadline passed, door away
		send_request(MODE_UNLOCK, 32'd20001, 1'b0, 1'b0);     // already unlocked
		send_request(MODE_SPARE_LO, 32'hFFFF_FFFF, 1'b1, 1'b1);
		send_request(MODE_SPARE_HI, 32'hFFFF_FFFF, 1'b0, 1'b0);
		send_request(MODE_START, 32'hFFFF_FFFF, 1'b1, 1'b0);
		send_request(MODE_READ, 32'hFFFF_FFFF, 1'b1, 1'b1);

		// random phases over several timing sets
		for (int phase = 0; phase < PHASES; phase++) begin
			clock_ms = $urandom;
			case (phase)
				0: begin
					step_max = 5000;
					flip_pct = 5;
				end
				1: begin
					retime(32'd100, 32'd20, 32'd150);
					step_max = 30;
					flip_pct = 8;
				end
				2: begin
					retime(32'd0, 32'd0, 32'd0);
					step_max = 5;
					flip_pct = 20;
				end
				3: begin
					retime(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
					step_max = 1000;
					flip_pct = 10;
				end
				4: begin
					retime($urandom_range(50, 400), $urandom_range(0, 60),
						$urandom_range(50, 500));
					clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
					step_max = 40;
					flip_pct = 8;
				end
				default: begin
					retime(pick_timing(), pick_timing(), pick_timing());
					step_max = 50;
					flip_pct = 10;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 50 == 0) begin
					send_gap_pct = 20 * $urandom_range(2);
					stall_pct    = 20 * $urandom_range(2);
				end
				if (phase == PHASES - 1 && n >= PHASE_ITEMS - CALM_ITEMS)
					calm = 1'b1;
				random_request();
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("door_lock_controller_top regression: pass");
		else
			$display("door_lock_controller_top regression: fail");
		$finish;
	end

endmodule

### sim.f
rtl/core/dlc_pkg.sv
rtl/core/dlc_cfg_regs.sv
rtl/core/dlc_lock_fsm.sv
rtl/core/door_lock_controller_top.sv
tb/sv/door_lock_monitor.sv
tb/sv/tb.sv
